// ===== design/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg
// Shared widths, sizes and operation codes of the sparse polynomial core.
// ----------------------------------------------------------------------------
package spa_pkg;

   // exponent span of one operand store and input coefficient width in use
   localparam int EXP_SPAN      = 32;
   localparam int COEF_IN_WIDTH = 16;

   localparam int HALF_SPAN = EXP_SPAN / 2;
   localparam int RES_DEPTH = 2 * EXP_SPAN - 1;
   localparam int IDX_W     = $clog2(EXP_SPAN);
   localparam int K_W       = $clog2(RES_DEPTH);

   // fixed field widths
   localparam int COEF_W    = 16;
   localparam int EXP_W     = 5;
   localparam int EXP_RES_W = 6;
   localparam int OP_W      = 2;
   localparam int IN_IDX_W  = EXP_W + 2;

   // datapath widths
   localparam int STORE_W = 24;
   localparam int PROD_W  = 2 * STORE_W;
   localparam int RES_W   = 53;
   localparam int EXW     = 8;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;

   // clamp a one-bit-grown sum back into the store range
   function automatic logic signed [STORE_W-1:0] sat_store(
      input logic signed [STORE_W:0] v
   );
      logic signed [STORE_W-1:0] r;
      if (v[STORE_W] != v[STORE_W-1]) begin
         r = {v[STORE_W], {(STORE_W-1){~v[STORE_W]}}};
      end else begin
         r = v[STORE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/sparse_polynomial_arithmetic_core.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_arithmetic_core
// Collects terms of two polynomials and emits A+B, A-B or A*B term by term.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one term per word (operand, coefficient, exponent, last).
//    Terms of equal exponent are summed per operand with saturation. The
//    term with req_last set starts the job; req_ready stays low until the
//    final result word is loaded.
//  - rsp_ channel: nonzero result terms in descending exponent order, the
//    final one with rsp_last_res set. A zero polynomial gives one word with
//    rsp_empty_res and rsp_last_res set.
//  - csr_ channel: the operation register, always ready; write only while idle.
//  - One multiply-accumulate unit works one result exponent at a time: for
//    multiply it sums EXP_SPAN products for each of 2*EXP_SPAN-1 exponents,
//    for add and subtract one sum or difference for each of EXP_SPAN exponents.
//  - A stalled receiver holds the word in the output register; the sequencer
//    waits only when another word is ready to go out while that register is full.
//  - Reset clears the operand stores, the operation, the state and the valid flags.
// ----------------------------------------------------------------------------
module sparse_polynomial_arithmetic_core
   import spa_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operand_select,
   input  logic signed [COEF_W-1:0]    req_coef,
   input  logic signed [EXP_W-1:0]     req_exponent,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [EXP_RES_W-1:0] rsp_exponent_res,
   output logic signed [RES_W-1:0]     rsp_coef_res,
   output logic                        rsp_empty_res,
   output logic                        rsp_last_res,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [OP_W-1:0]             csr_operation
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_RESULT,
      ST_FLUSH
   } state_type;

   // operand stores
   logic signed [STORE_W-1:0] a_mem_ff [EXP_SPAN];
   logic signed [STORE_W-1:0] b_mem_ff [EXP_SPAN];
   logic [EXP_SPAN-1:0]       a_vld_ff, b_vld_ff;

   // control
   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff;
   logic [K_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]  i_ff, i_in;

   // shared unit pipeline
   logic                      s1_vld_ff, s1_vld_in;
   logic                      s1_first_ff, s1_first_in;
   logic signed [STORE_W-1:0] op_a_ff, op_a_in;
   logic signed [STORE_W-1:0] op_b_ff, op_b_in;
   logic                      s2_vld_ff;
   logic                      s2_first_ff;
   logic signed [PROD_W-1:0]  val_ff, val_in;
   logic signed [RES_W-1:0]   acc_ff, acc_in;

   // held term and output register
   logic                        pend_vld_ff, pend_vld_in;
   logic signed [EXP_RES_W-1:0] pend_exp_ff, pend_exp_in;
   logic signed [RES_W-1:0]     pend_coef_ff, pend_coef_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [EXP_RES_W-1:0] rsp_exp_ff, rsp_exp_in;
   logic signed [RES_W-1:0]     rsp_coef_ff, rsp_coef_in;
   logic                        rsp_empty_ff, rsp_empty_in;
   logic                        rsp_last_ff, rsp_last_in;

   // combinational
   logic                      mul_mode, req_fire, rsp_free, store_clr;
   logic                      in_range, j_ok, acc_nz;
   logic signed [IN_IDX_W-1:0] in_idx_wide;
   logic [IDX_W-1:0]          in_idx, addr_a, addr_b, i_end;
   logic [K_W:0]              j_wide;
   logic signed [STORE_W-1:0] a_rd, b_rd, old_rd, store_new;
   logic signed [STORE_W:0]   coef_ext, store_sum, addsub;
   logic signed [EXW-1:0]     ex_wide;

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_exponent_res = rsp_exp_ff;
   assign rsp_coef_res     = rsp_coef_ff;
   assign rsp_empty_res    = rsp_empty_ff;
   assign rsp_last_res     = rsp_last_ff;

   always_comb begin
      mul_mode = (op_ff == OP_MUL);
      req_fire = req_valid && req_ready;
      rsp_free = !rsp_valid_ff || rsp_ready;

      in_idx_wide = {{2{req_exponent[EXP_W-1]}}, req_exponent}
                    + IN_IDX_W'(HALF_SPAN);
      in_range    = !in_idx_wide[IN_IDX_W-1]
                    && (in_idx_wide[IN_IDX_W-2:0] < (IN_IDX_W-1)'(EXP_SPAN));
      in_idx      = in_idx_wide[IDX_W-1:0];

      j_wide = (K_W+1)'(k_ff) - (K_W+1)'(i_ff);
      j_ok   = !j_wide[K_W] && (j_wide[K_W-1:0] < K_W'(EXP_SPAN));

      if (state_ff == ST_IDLE) begin
         addr_a = in_idx;
         addr_b = in_idx;
      end else if (mul_mode) begin
         addr_a = i_ff;
         addr_b = j_wide[IDX_W-1:0];
      end else begin
         addr_a = k_ff[IDX_W-1:0];
         addr_b = k_ff[IDX_W-1:0];
      end
      a_rd = a_vld_ff[addr_a] ? a_mem_ff[addr_a] : '0;
      b_rd = b_vld_ff[addr_b] ? b_mem_ff[addr_b] : '0;

      // term merge
      coef_ext  = {{(STORE_W+1-COEF_IN_WIDTH){req_coef[COEF_IN_WIDTH-1]}},
                   req_coef[COEF_IN_WIDTH-1:0]};
      old_rd    = req_operand_select ? b_rd : a_rd;
      store_sum = {old_rd[STORE_W-1], old_rd} + coef_ext;
      store_new = sat_store(store_sum);

      // shared unit: multiply, or add/subtract
      op_a_in = a_rd;
      op_b_in = (mul_mode && !j_ok) ? '0 : b_rd;
      if (op_ff == OP_SUB) begin
         addsub = {op_a_ff[STORE_W-1], op_a_ff} - {op_b_ff[STORE_W-1], op_b_ff};
      end else begin
         addsub = {op_a_ff[STORE_W-1], op_a_ff} + {op_b_ff[STORE_W-1], op_b_ff};
      end
      if (mul_mode) begin
         val_in = op_a_ff * op_b_ff;
      end else begin
         val_in = {{(PROD_W-STORE_W-1){addsub[STORE_W]}}, addsub};
      end
      acc_in = (s2_first_ff ? RES_W'(0) : acc_ff)
               + {{(RES_W-PROD_W){val_ff[PROD_W-1]}}, val_ff};

      acc_nz  = (acc_ff != '0);
      ex_wide = EXW'(k_ff) - (mul_mode ? EXW'(2 * HALF_SPAN) : EXW'(HALF_SPAN));
      i_end   = mul_mode ? IDX_W'(EXP_SPAN - 1) : '0;

      // defaults
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      s1_vld_in    = 1'b0;
      s1_first_in  = (i_ff == '0);
      pend_vld_in  = pend_vld_ff;
      pend_exp_in  = pend_exp_ff;
      pend_coef_in = pend_coef_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_exp_in   = rsp_exp_ff;
      rsp_coef_in  = rsp_coef_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      store_clr    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_last) begin
               k_in     = mul_mode ? K_W'(RES_DEPTH - 1) : K_W'(EXP_SPAN - 1);
               i_in     = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            s1_vld_in = 1'b1;
            if (i_ff == i_end) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!(acc_nz && pend_vld_ff && !rsp_free)) begin
               if (acc_nz) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_exp_in   = pend_exp_ff;
                     rsp_coef_in  = pend_coef_ff;
                     rsp_empty_in = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_exp_in  = ex_wide[EXP_RES_W-1:0];
                  pend_coef_in = acc_ff;
               end
               i_in = '0;
               if (k_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  k_in     = k_ff - 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FLUSH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_exp_in   = pend_vld_ff ? pend_exp_ff : '0;
               rsp_coef_in  = pend_vld_ff ? pend_coef_ff : '0;
               rsp_empty_in = !pend_vld_ff;
               pend_vld_in  = 1'b0;
               store_clr    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ADD;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s1_vld_ff;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            op_ff <= csr_operation;
         end
      end
      k_ff         <= k_in;
      i_ff         <= i_in;
      s1_first_ff  <= s1_first_in;
      op_a_ff      <= op_a_in;
      op_b_ff      <= op_b_in;
      s2_first_ff  <= s1_first_ff;
      val_ff       <= val_in;
      pend_exp_ff  <= pend_exp_in;
      pend_coef_ff <= pend_coef_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_coef_ff  <= rsp_coef_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // store entries; an entry without its valid bit reads as zero
   always_ff @(posedge clock) begin
      if (reset || store_clr) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else if (req_fire && in_range) begin
         if (req_operand_select) begin
            b_vld_ff[in_idx] <= 1'b1;
         end else begin
            a_vld_ff[in_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && in_range) begin
         if (req_operand_select) begin
            b_mem_ff[in_idx] <= store_new;
         end else begin
            a_mem_ff[in_idx] <= store_new;
         end
      end
   end

   // checks
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_vld_ff && !s2_vld_ff && !pend_vld_ff))
      else $error("shared unit busy or term held while idle");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("ready after job start");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_last_res && rsp_coef_res == '0))
      else $error("empty word malformed");

   a_nonzero_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_res) |-> (rsp_coef_res != '0))
      else $error("zero coefficient emitted");

   a_issue_idle_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT) |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("result taken before pipeline drained");

endmodule

// ===== tb/poly_term_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_term_checker
// Watches the term, result and operation channels of the sparse polynomial
// core. Keeps its own operand stores, forms A+B, A-B or A*B when a job's
// final term goes in, and compares every result word with the oldest
// prediction. Hands the mismatch count and the number of outstanding words
// to the testbench top.
// ----------------------------------------------------------------------------
module poly_term_checker
   import spa_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_operand_select,
   input  logic signed [COEF_W-1:0]    req_coef,
   input  logic signed [EXP_W-1:0]     req_exponent,
   input  logic                        req_last,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [EXP_RES_W-1:0] rsp_exponent_res,
   input  logic signed [RES_W-1:0]     rsp_coef_res,
   input  logic                        rsp_empty_res,
   input  logic                        rsp_last_res,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [OP_W-1:0]             csr_operation,
   output int                          fail_count,
   output int                          pending_words
);

   typedef struct packed {
      logic signed [EXP_RES_W-1:0] exponent;
      logic signed [RES_W-1:0]     coef;
      logic                        empty;
      logic                        last;
   } result_word_type;

   localparam longint STORE_HI = 64'sd8388607;
   localparam longint STORE_LO = -64'sd8388608;
   localparam longint RES_HI   = 64'sd4503599627370495;
   localparam longint RES_LO   = -64'sd4503599627370496;

   logic signed [STORE_W-1:0] a_terms [EXP_SPAN];
   logic signed [STORE_W-1:0] b_terms [EXP_SPAN];
   logic [OP_W-1:0]           op_sel;
   result_word_type           expected_words [$];
   int                        mismatches = 0;

   assign fail_count = mismatches;

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      mismatches++;
   endtask

   task automatic clear_stores();
      foreach (a_terms[i]) begin
         a_terms[i] = '0;
         b_terms[i] = '0;
      end
   endtask

   task automatic merge_term(logic sel, logic signed [COEF_W-1:0] coef,
                             logic signed [EXP_W-1:0] ex);
      int     idx;
      longint sum;
      idx = int'(ex) + HALF_SPAN;
      if (idx >= 0 && idx < EXP_SPAN) begin
         if (sel) begin
            sum = clip(longint'(b_terms[idx]) + longint'(coef), STORE_LO, STORE_HI);
            b_terms[idx] = STORE_W'(sum);
         end else begin
            sum = clip(longint'(a_terms[idx]) + longint'(coef), STORE_LO, STORE_HI);
            a_terms[idx] = STORE_W'(sum);
         end
      end
   endtask

   // forms the result polynomial, queues its words high exponent first
   task automatic predict_job();
      longint          acc [RES_DEPTH];
      int              nonzero;
      int              seen;
      result_word_type w;
      nonzero = 0;
      seen = 0;
      for (int k = 0; k < RES_DEPTH; k++) acc[k] = 0;
      if (op_sel == OP_MUL) begin
         for (int i = 0; i < EXP_SPAN; i++) begin
            for (int j = 0; j < EXP_SPAN; j++) begin
               acc[i + j] += longint'(a_terms[i]) * longint'(b_terms[j]);
            end
         end
      end else begin
         for (int i = 0; i < EXP_SPAN; i++) begin
            if (op_sel == OP_SUB) acc[i + HALF_SPAN] = longint'(a_terms[i]) - longint'(b_terms[i]);
            else acc[i + HALF_SPAN] = longint'(a_terms[i]) + longint'(b_terms[i]);
         end
      end
      for (int k = 0; k < RES_DEPTH; k++) begin
         acc[k] = clip(acc[k], RES_LO, RES_HI);
         if (acc[k] != 0) nonzero++;
      end
      for (int k = RES_DEPTH - 1; k >= 0; k--) begin
         if (acc[k] != 0) begin
            seen++;
            w.exponent = EXP_RES_W'(k - 2 * HALF_SPAN);
            w.coef     = RES_W'(acc[k]);
            w.empty    = 1'b0;
            w.last     = (seen == nonzero);
            expected_words.push_back(w);
         end
      end
      if (nonzero == 0) begin
         w.exponent = '0;
         w.coef     = '0;
         w.empty    = 1'b1;
         w.last     = 1'b1;
         expected_words.push_back(w);
      end
      clear_stores();
   endtask

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         op_sel = OP_ADD;
         clear_stores();
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word, exponent_res", rsp_exponent_res, 0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_exponent_res !== want.exponent)
                  report_mismatch("exponent_res", rsp_exponent_res, want.exponent);
               if (rsp_coef_res !== want.coef)
                  report_mismatch("coef_res", rsp_coef_res, want.coef);
               if (rsp_empty_res !== want.empty)
                  report_mismatch("empty_res", rsp_empty_res, want.empty);
               if (rsp_last_res !== want.last)
                  report_mismatch("last_res", rsp_last_res, want.last);
            end
         end
         if (csr_valid && csr_ready) op_sel = csr_operation;
         if (req_valid && req_ready) begin
            merge_term(req_operand_select, req_coef, req_exponent);
            if (req_last) predict_job();
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sparse polynomial core: directed jobs over every
// operation, extreme terms and cancellation, then random jobs under random
// operations with random gaps on both channels and one long receiver
// hold-off. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb
   import spa_pkg::*;
();

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, behaves as add
   localparam int STALL_LIMIT  = 30000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int RANDOM_TERMS = 180;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_operand_select;
   logic signed [COEF_W-1:0]    req_coef;
   logic signed [EXP_W-1:0]     req_exponent;
   logic                        req_last;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [EXP_RES_W-1:0] rsp_exponent_res;
   logic signed [RES_W-1:0]     rsp_coef_res;
   logic                        rsp_empty_res;
   logic                        rsp_last_res;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [OP_W-1:0]             csr_operation;
   int                          fail_count;
   int                          pending_words;
   int                          idle_cycles;
   int                          random_terms;
   bit                          hold_request;
   bit                          hold_done;

   sparse_polynomial_arithmetic_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operand_select (req_operand_select),
      .req_coef           (req_coef),
      .req_exponent       (req_exponent),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_exponent_res   (rsp_exponent_res),
      .rsp_coef_res       (rsp_coef_res),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_last_res       (rsp_last_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_operation      (csr_operation)
   );

   poly_term_checker term_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operand_select (req_operand_select),
      .req_coef           (req_coef),
      .req_exponent       (req_exponent),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_exponent_res   (rsp_exponent_res),
      .rsp_coef_res       (rsp_coef_res),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_last_res       (rsp_last_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_operation      (csr_operation),
      .fail_count         (fail_count),
      .pending_words      (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic req_pause(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_term(bit sel, int coef, int ex, bit fin);
      req_valid          <= 1'b1;
      req_operand_select <= sel;
      req_coef           <= COEF_W'(coef);
      req_exponent       <= EXP_W'(ex);
      req_last           <= fin;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_operation(logic [OP_W-1:0] op);
      csr_valid     <= 1'b1;
      csr_operation <= op;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // stop offering words until every predicted result word is back
   task automatic wait_results();
      req_pause(1);
      while (pending_words != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic logic [OP_W-1:0] pick_operation();
      case ($urandom_range(0, 3))
         0: return OP_ADD;
         1: return OP_SUB;
         2: return OP_MUL;
         default: return OP_SPARE;
      endcase
   endfunction

   task automatic random_job();
      int n_terms;
      int coef;
      int ex;
      bit eager;
      int pool [3];
      n_terms = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      eager = ($urandom_range(0, 3) == 0);
      foreach (pool[k]) pool[k] = $urandom_range(0, 31);
      for (int t = 0; t < n_terms; t++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: coef = $urandom;
            5: coef = $urandom_range(0, 1) ? 32767 : -32768;
            6: coef = $urandom_range(0, 8) - 4;
            7: coef = 0;
            default: coef = $urandom_range(0, 200) - 100;
         endcase
         ex = $urandom_range(0, 1) ? $urandom_range(0, 31) : pool[$urandom_range(0, 2)];
         send_term($urandom_range(0, 1), coef, ex, t == n_terms - 1);
         random_terms++;
         if (!eager) req_pause(sender_gap());
      end
   endtask

   initial begin : receiver
      int burst;
      int gap;
      int r;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         r = $urandom_range(0, 99);
         burst = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 20);
         rsp_ready <= 1'b1;
         repeat (burst) @(posedge clock);
         r = $urandom_range(0, 99);
         gap = (r < 45) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int n_jobs;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operand_select = 1'b0;
      req_coef           = '0;
      req_exponent       = '0;
      req_last           = 1'b0;
      csr_valid          = 1'b0;
      csr_operation      = OP_ADD;
      hold_request       = 1'b0;
      hold_done          = 1'b0;
      random_terms       = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // add: extreme terms, then a cancelling pair and a lone zero term
      write_operation(OP_ADD);
      send_term(0, 32767, 15, 0);
      send_term(0, -32768, -16, 0);
      send_term(1, 1, 15, 0);
      send_term(1, -1, 0, 0);
      send_term(1, 5, -16, 1);
      send_term(0, 100, 3, 0);
      send_term(1, -100, 3, 1);
      send_term(0, 0, 0, 1);
      wait_results();

      // subtract: B negated with and without an A partner
      write_operation(OP_SUB);
      send_term(0, 7, 2, 0);
      send_term(1, 7, 2, 0);
      send_term(1, -3, -5, 1);
      send_term(1, -32768, 15, 1);
      wait_results();

      // multiply: exponent extremes of the product, then B left empty
      write_operation(OP_MUL);
      send_term(0, 32767, 15, 0);
      send_term(0, -32768, -16, 0);
      send_term(1, 32767, 15, 0);
      send_term(1, -32768, -16, 1);
      send_term(0, 9, 4, 1);
      wait_results();

      write_operation(OP_SPARE);
      send_term(0, 1, 1, 0);
      send_term(1, 2, 1, 1);
      wait_results();

      while (random_terms < RANDOM_TERMS) begin
         write_operation(pick_operation());
         n_jobs = $urandom_range(1, 4);
         repeat (n_jobs) begin
            if (random_terms >= RANDOM_TERMS / 2) hold_request = 1'b1;
            random_job();
         end
         wait_results();
      end
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending_words == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
